// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/gaoi_pkg.sv =====
package gaoi_pkg;

  // APB address width: three 32-bit registers.
  localparam int AddrW = 4;

  // Function codes.
  localparam logic [2:0] FnAdd     = 3'd0;
  localparam logic [2:0] FnDelete  = 3'd1;
  localparam logic [2:0] FnMove    = 3'd2;
  localparam logic [2:0] FnCell    = 3'd3;
  localparam logic [2:0] FnWindow  = 3'd4;
  localparam logic [2:0] FnCompare = 3'd5;
  localparam logic [2:0] FnBox     = 3'd6;

  // Status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StExists   = 3'd2;
  localparam logic [2:0] StRange    = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;
  localparam logic [2:0] StTooLarge = 3'd5;

  // Region codes.
  localparam logic [1:0] RgnPlain = 2'd0;
  localparam logic [1:0] RgnNew   = 2'd1;
  localparam logic [1:0] RgnOld   = 2'd2;
  localparam logic [1:0] RgnBoth  = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic [1:0]         half_w;
    logic [1:0]         half_h;
    logic [31:0]        id;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       cell_valid;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [8:0] cell_count;
    logic [1:0] region;
    logic       last;
  } res_t;

  // Active grid size and capacity, already clipped to the build limits.
  typedef struct packed {
    logic [6:0] act_w;
    logic [6:0] act_h;
    logic [8:0] act_cap;
  } cfg_t;

endpackage

// ===== hdl/gaoi_regs.sv =====
module gaoi_regs #(
  parameter int GRID_W      = 64,
  parameter int GRID_H      = 64,
  parameter int MAX_OBJECTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gaoi_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output gaoi_pkg::cfg_t             cfg_o
);

  localparam logic [1:0] RegIdxWidth  = 2'd0;
  localparam logic [1:0] RegIdxHeight = 2'd1;
  localparam logic [1:0] RegIdxCap    = 2'd2;

  localparam int LimW   = (GRID_W < 64) ? GRID_W : 64;
  localparam int LimH   = (GRID_H < 64) ? GRID_H : 64;
  localparam int LimCap = (MAX_OBJECTS < 511) ? MAX_OBJECTS : 511;

  logic [6:0] width_q, height_q;
  logic [8:0] cap_q;
  logic       wr;
  logic [1:0] idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      cap_q    <= 9'd256;
    end else if (wr) begin
      case (idx)
        RegIdxWidth:  width_q  <= pwdata[6:0];
        RegIdxHeight: height_q <= pwdata[6:0];
        RegIdxCap:    cap_q    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegIdxWidth:  prdata = 32'(width_q);
      RegIdxHeight: prdata = 32'(height_q);
      RegIdxCap:    prdata = 32'(cap_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.act_w   = (32'(width_q) > LimW) ? 7'(LimW) : width_q;
    cfg_o.act_h   = (32'(height_q) > LimH) ? 7'(LimH) : height_q;
    cfg_o.act_cap = (32'(cap_q) > LimCap) ? 9'(LimCap) : cap_q;
  end

endmodule

// ===== hdl/grid_area_occupancy_index.sv =====
// Grid occupancy index: per-cell object counts plus an object table.
// Command channel: present cmd_i with start high; the item is taken on the
// edge where start is high and busy is low. busy stays high until the last
// result of the item has been issued.
// Result channel: each result shows on res_o for one cycle with res_valid_o
// high; res_o.last marks the final one. The receiver cannot stall, so
// results flow out at whatever rate the engine produces them.
// Add, delete and move walk the whole object table (one entry per cycle out
// of a memory with separate read and write ports), then on success do a
// read-modify-write of one or two cell counters. Queries step the window or
// box one cell per cycle through the cell-count memory; a compare scans the
// new window and then the old one. One result is held back so the last flag
// is known.
// Reset: a clearing pass writes every cell counter and table entry to zero,
// with busy high.
// Configuration goes through the APB port; write it only while idle.
`include "assert_macros.svh"

module grid_area_occupancy_index #(
  parameter int GRID_W        = 64,
  parameter int GRID_H        = 64,
  parameter int MAX_OBJECTS   = 256,
  parameter int MAX_HALF      = 2,
  parameter int MAX_BOX_CELLS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  gaoi_pkg::cmd_t             cmd_i,
  output logic                       res_valid_o,
  output gaoi_pkg::res_t             res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gaoi_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CDEPTH = GRID_W * GRID_H;
  localparam int CAW    = $clog2((CDEPTH > 1) ? CDEPTH : 2);
  localparam int SW     = $clog2((MAX_OBJECTS > 1) ? MAX_OBJECTS : 2);
  localparam int CW     = $clog2(MAX_OBJECTS + 1);
  localparam int TW     = $clog2(MAX_OBJECTS + 1);
  localparam int NCLR0  = (CDEPTH > MAX_OBJECTS) ? CDEPTH : MAX_OBJECTS;
  localparam int NCLR   = (NCLR0 > 1) ? NCLR0 : 2;
  localparam int CLRW   = $clog2(NCLR);
  localparam logic [1:0] MaxHalfL = 2'(MAX_HALF);

  typedef struct packed {
    logic        used;
    logic [31:0] ident;
    logic [5:0]  col;
    logic [5:0]  row;
  } slot_t;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_DECODE   = 10'b0000000100,
    S_SLOTSCAN = 10'b0000001000,
    S_SLOTDONE = 10'b0000010000,
    S_CELLRD   = 10'b0000100000,
    S_CELLWR   = 10'b0001000000,
    S_SCAN     = 10'b0010000000,
    S_DRAIN    = 10'b0100000000,
    S_RESULT   = 10'b1000000000
  } state_e;

  gaoi_pkg::cfg_t cfg;

  gaoi_regs #(
    .GRID_W      (GRID_W),
    .GRID_H      (GRID_H),
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Memories
  logic [CW-1:0] cell_mem [CDEPTH];
  slot_t         slot_mem [MAX_OBJECTS];

  logic          cr_en, cw_en, sr_en, sw_en;
  logic [CAW-1:0] cr_addr, cw_addr;
  logic [CW-1:0] cw_data, cell_rd_q;
  logic [SW-1:0] sr_addr, sw_addr;
  slot_t         sw_data, slot_rd_q;

  always_ff @(posedge clk_i) begin
    if (cw_en) cell_mem[cw_addr] <= cw_data;
    if (cr_en) cell_rd_q <= cell_mem[cr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) slot_mem[sw_addr] <= sw_data;
    if (sr_en) slot_rd_q <= slot_mem[sr_addr];
  end

  // Control and datapath registers
  state_e              state_q, state_d;
  logic [CLRW-1:0]     clr_q, clr_d;
  gaoi_pkg::cmd_t      cmd_q, cmd_d;
  logic [2:0]          status_q, status_d;
  logic [TW-1:0]       total_q, total_d;
  logic [1:0]          hw_q, hw_d, hh_q, hh_d;
  // table walk
  logic [SW-1:0]       sidx_q, sidx_d, ridx_q, ridx_d;
  logic                iss_done_q, iss_done_d, rdv_q, rdv_d;
  logic                found_q, found_d, free_v_q, free_v_d;
  logic [SW-1:0]       fidx_q, fidx_d, free_idx_q, free_idx_d;
  logic [5:0]          fcol_q, fcol_d, frow_q, frow_d;
  // counter updates
  logic                dec_pend_q, dec_pend_d, inc_pend_q, inc_pend_d;
  logic [CAW-1:0]      dec_addr_q, dec_addr_d, inc_addr_q, inc_addr_d;
  // cell scan
  logic signed [17:0]  bx_q, bx_d, by_q, by_d, ox_q, ox_d, oy_q, oy_d;
  logic [6:0]          i_q, i_d, j_q, j_d, nx_q, nx_d, ny_q, ny_d;
  logic [1:0]          mode_q, mode_d;
  logic                pv_q, pv_d;
  logic [5:0]          ppx_q, ppx_d, ppy_q, ppy_d;
  logic [1:0]          preg_q, preg_d;
  logic                pend_v_q, pend_v_d;
  gaoi_pkg::res_t      pend_q, pend_d;
  logic                res_valid_q, res_valid_d;
  gaoi_pkg::res_t      res_q, res_d;

  function automatic logic inr(logic signed [17:0] px, logic signed [17:0] py,
                               logic [6:0] w, logic [6:0] h);
    return !px[17] && !py[17] && (px < signed'(18'(w))) && (py < signed'(18'(h)));
  endfunction

  function automatic logic [CAW-1:0] caddr(logic [5:0] c, logic [5:0] r);
    return CAW'(32'(c) * GRID_H + 32'(r));
  endfunction

  function automatic logic [8:0] sat9(logic [CW-1:0] c);
    return (32'(c) > 511) ? 9'd511 : 9'(c);
  endfunction

  // Derived values for decode and scan
  logic signed [17:0] sx, sy, sx2, sy2, hw18, hh18, px, py, dx, dy;
  logic [1:0]         hw_c, hh_c;
  logic [16:0]        nx17, ny17;
  logic [33:0]        box_cells;
  logic               in_old, cmd_inr;

  always_comb begin
    sx   = 18'(cmd_q.x);
    sy   = 18'(cmd_q.y);
    sx2  = 18'(cmd_q.x2);
    sy2  = 18'(cmd_q.y2);
    hw_c = (cmd_q.half_w > MaxHalfL) ? MaxHalfL : cmd_q.half_w;
    hh_c = (cmd_q.half_h > MaxHalfL) ? MaxHalfL : cmd_q.half_h;
    hw18 = signed'(18'(hw_q));
    hh18 = signed'(18'(hh_q));
    dx   = sx2 - sx;
    dy   = sy2 - sy;
    nx17 = 17'(dx) + 17'd1;
    ny17 = 17'(dy) + 17'd1;
    box_cells = 34'(nx17) * 34'(ny17);
    cmd_inr = inr(sx, sy, cfg.act_w, cfg.act_h);
    px   = bx_q + signed'(18'(i_q));
    py   = by_q + signed'(18'(j_q));
    in_old = (px >= ox_q - hw18) && (px <= ox_q + hw18) &&
             (py >= oy_q - hh18) && (py <= oy_q + hh18);
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    total_d    = total_q;
    hw_d       = hw_q;
    hh_d       = hh_q;
    sidx_d     = sidx_q;
    ridx_d     = sidx_q;
    iss_done_d = iss_done_q;
    rdv_d      = 1'b0;
    found_d    = found_q;
    free_v_d   = free_v_q;
    fidx_d     = fidx_q;
    free_idx_d = free_idx_q;
    fcol_d     = fcol_q;
    frow_d     = frow_q;
    dec_pend_d = dec_pend_q;
    inc_pend_d = inc_pend_q;
    dec_addr_d = dec_addr_q;
    inc_addr_d = inc_addr_q;
    bx_d = bx_q; by_d = by_q; ox_d = ox_q; oy_d = oy_q;
    i_d = i_q; j_d = j_q; nx_d = nx_q; ny_d = ny_q;
    mode_d     = mode_q;
    pv_d       = 1'b0;
    ppx_d      = ppx_q;
    ppy_d      = ppy_q;
    preg_d     = preg_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    res_valid_d = 1'b0;
    res_d      = res_q;
    cr_en = 1'b0; cr_addr = '0;
    cw_en = 1'b0; cw_addr = '0; cw_data = '0;
    sr_en = 1'b0; sr_addr = '0;
    sw_en = 1'b0; sw_addr = '0; sw_data = '0;

    // Cell data returns in the cycle after a scan read; hold one result back
    // so that the final one can carry the last flag.
    if (pv_q && (cell_rd_q != '0)) begin
      if (pend_v_q) begin
        res_valid_d = 1'b1;
        res_d       = pend_q;
        res_d.status = status_q;
      end
      pend_v_d          = 1'b1;
      pend_d.status     = gaoi_pkg::StOk;
      pend_d.cell_valid = 1'b1;
      pend_d.cell_x     = ppx_q;
      pend_d.cell_y     = ppy_q;
      pend_d.cell_count = sat9(cell_rd_q);
      pend_d.region     = preg_q;
      pend_d.last       = 1'b0;
    end

    // Table entry returns in the cycle after the walk read.
    if (rdv_q) begin
      if (slot_rd_q.used && (slot_rd_q.ident == cmd_q.id) && !found_q) begin
        found_d = 1'b1;
        fidx_d  = ridx_q;
        fcol_d  = slot_rd_q.col;
        frow_d  = slot_rd_q.row;
      end
      if (!slot_rd_q.used && !free_v_q) begin
        free_v_d   = 1'b1;
        free_idx_d = ridx_q;
      end
    end

    case (state_q)
      S_CLEAR: begin
        if (32'(clr_q) < CDEPTH) begin
          cw_en   = 1'b1;
          cw_addr = clr_q[CAW-1:0];
        end
        if (32'(clr_q) < MAX_OBJECTS) begin
          sw_en   = 1'b1;
          sw_addr = clr_q[SW-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CLRW'(NCLR - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_i;
          pend_v_d = 1'b0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d   = gaoi_pkg::StOk;
        hw_d       = hw_c;
        hh_d       = hh_c;
        i_d        = '0;
        j_d        = '0;
        mode_d     = gaoi_pkg::RgnPlain;
        sidx_d     = '0;
        iss_done_d = 1'b0;
        found_d    = 1'b0;
        free_v_d   = 1'b0;
        dec_pend_d = 1'b0;
        inc_pend_d = 1'b0;
        case (cmd_q.func)
          gaoi_pkg::FnAdd, gaoi_pkg::FnDelete, gaoi_pkg::FnMove: begin
            state_d = S_SLOTSCAN;
          end
          gaoi_pkg::FnCell: begin
            if (!cmd_inr) begin
              status_d = gaoi_pkg::StRange;
              state_d  = S_RESULT;
            end else begin
              bx_d = sx; by_d = sy;
              nx_d = 7'd1; ny_d = 7'd1;
              state_d = S_SCAN;
            end
          end
          gaoi_pkg::FnWindow, gaoi_pkg::FnCompare: begin
            bx_d = sx - signed'(18'(hw_c));
            by_d = sy - signed'(18'(hh_c));
            ox_d = sx2;
            oy_d = sy2;
            nx_d = 7'({hw_c, 1'b1});
            ny_d = 7'({hh_c, 1'b1});
            if (cmd_q.func == gaoi_pkg::FnCompare) mode_d = gaoi_pkg::RgnNew;
            state_d = S_SCAN;
          end
          gaoi_pkg::FnBox: begin
            if (dx[17] || dy[17]) begin
              state_d = S_RESULT;
            end else if (box_cells > 34'(MAX_BOX_CELLS)) begin
              status_d = gaoi_pkg::StTooLarge;
              state_d  = S_RESULT;
            end else begin
              bx_d = sx; by_d = sy;
              nx_d = 7'(nx17);
              ny_d = 7'(ny17);
              state_d = S_SCAN;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end

      S_SLOTSCAN: begin
        if (!iss_done_q) begin
          sr_en  = 1'b1;
          sr_addr = sidx_q;
          rdv_d  = 1'b1;
          ridx_d = sidx_q;
          sidx_d = sidx_q + 1'b1;
          if (sidx_q == SW'(MAX_OBJECTS - 1)) iss_done_d = 1'b1;
        end else if (!rdv_q) begin
          state_d = S_SLOTDONE;
        end
      end

      S_SLOTDONE: begin
        state_d = S_RESULT;
        case (cmd_q.func)
          gaoi_pkg::FnAdd: begin
            if (32'(total_q) >= 32'(cfg.act_cap)) status_d = gaoi_pkg::StFull;
            else if (found_q)                     status_d = gaoi_pkg::StExists;
            else if (!cmd_inr)                    status_d = gaoi_pkg::StRange;
            else if (!free_v_q)                   status_d = gaoi_pkg::StFull;
            else begin
              sw_en   = 1'b1;
              sw_addr = free_idx_q;
              sw_data = '{used: 1'b1, ident: cmd_q.id,
                          col: cmd_q.x[5:0], row: cmd_q.y[5:0]};
              total_d    = total_q + 1'b1;
              inc_pend_d = 1'b1;
              inc_addr_d = caddr(cmd_q.x[5:0], cmd_q.y[5:0]);
              state_d    = S_CELLRD;
            end
          end
          gaoi_pkg::FnDelete: begin
            if (!found_q) status_d = gaoi_pkg::StNotFound;
            else begin
              sw_en   = 1'b1;
              sw_addr = fidx_q;
              sw_data = '{used: 1'b0, ident: cmd_q.id, col: fcol_q, row: frow_q};
              if (total_q != '0) total_d = total_q - 1'b1;
              dec_pend_d = 1'b1;
              dec_addr_d = caddr(fcol_q, frow_q);
              state_d    = S_CELLRD;
            end
          end
          default: begin
            // move
            if (!cmd_inr)     status_d = gaoi_pkg::StRange;
            else if (!found_q) status_d = gaoi_pkg::StNotFound;
            else begin
              sw_en   = 1'b1;
              sw_addr = fidx_q;
              sw_data = '{used: 1'b1, ident: cmd_q.id,
                          col: cmd_q.x[5:0], row: cmd_q.y[5:0]};
              dec_pend_d = 1'b1;
              dec_addr_d = caddr(fcol_q, frow_q);
              inc_pend_d = 1'b1;
              inc_addr_d = caddr(cmd_q.x[5:0], cmd_q.y[5:0]);
              state_d    = S_CELLRD;
            end
          end
        endcase
      end

      S_CELLRD: begin
        cr_en   = 1'b1;
        cr_addr = dec_pend_q ? dec_addr_q : inc_addr_q;
        state_d = S_CELLWR;
      end

      S_CELLWR: begin
        // Decrement (old cell) goes before increment, so a move within one
        // cell reads back its own write.
        cw_en = 1'b1;
        if (dec_pend_q) begin
          cw_addr    = dec_addr_q;
          cw_data    = (cell_rd_q != '0) ? cell_rd_q - 1'b1 : cell_rd_q;
          dec_pend_d = 1'b0;
          state_d    = inc_pend_q ? S_CELLRD : S_RESULT;
        end else begin
          cw_addr    = inc_addr_q;
          cw_data    = cell_rd_q + 1'b1;
          inc_pend_d = 1'b0;
          state_d    = S_RESULT;
        end
      end

      S_SCAN: begin
        if (inr(px, py, cfg.act_w, cfg.act_h) &&
            ((mode_q != gaoi_pkg::RgnOld) || !in_old)) begin
          cr_en   = 1'b1;
          cr_addr = caddr(px[5:0], py[5:0]);
          pv_d    = 1'b1;
          ppx_d   = px[5:0];
          ppy_d   = py[5:0];
          if (mode_q == gaoi_pkg::RgnNew)
            preg_d = in_old ? gaoi_pkg::RgnBoth : gaoi_pkg::RgnNew;
          else
            preg_d = mode_q;
        end
        if (j_q == ny_q - 7'd1) begin
          j_d = '0;
          if (i_q == nx_q - 7'd1) begin
            i_d = '0;
            if (mode_q == gaoi_pkg::RgnNew) begin
              // second pass: old window, cells outside the new one
              mode_d = gaoi_pkg::RgnOld;
              bx_d   = sx2 - hw18;
              by_d   = sy2 - hh18;
              ox_d   = sx;
              oy_d   = sy;
            end else begin
              state_d = S_DRAIN;
            end
          end else begin
            i_d = i_q + 7'd1;
          end
        end else begin
          j_d = j_q + 7'd1;
        end
      end

      S_DRAIN: state_d = S_RESULT;

      S_RESULT: begin
        res_valid_d = 1'b1;
        if (pend_v_q) begin
          res_d = pend_q;
        end else begin
          res_d = '0;
        end
        res_d.status = status_q;
        res_d.last   = 1'b1;
        pend_v_d     = 1'b0;
        state_d      = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      iss_done_q  <= 1'b0;
      rdv_q       <= 1'b0;
      found_q     <= 1'b0;
      free_v_q    <= 1'b0;
      dec_pend_q  <= 1'b0;
      inc_pend_q  <= 1'b0;
      pv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      iss_done_q  <= iss_done_d;
      rdv_q       <= rdv_d;
      found_q     <= found_d;
      free_v_q    <= free_v_d;
      dec_pend_q  <= dec_pend_d;
      inc_pend_q  <= inc_pend_d;
      pv_q        <= pv_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    status_q   <= status_d;
    hw_q       <= hw_d;
    hh_q       <= hh_d;
    sidx_q     <= sidx_d;
    ridx_q     <= ridx_d;
    fidx_q     <= fidx_d;
    free_idx_q <= free_idx_d;
    fcol_q     <= fcol_d;
    frow_q     <= frow_d;
    dec_addr_q <= dec_addr_d;
    inc_addr_q <= inc_addr_d;
    bx_q <= bx_d; by_q <= by_d; ox_q <= ox_d; oy_q <= oy_d;
    i_q <= i_d; j_q <= j_d; nx_q <= nx_d; ny_q <= ny_d;
    mode_q     <= mode_d;
    ppx_q      <= ppx_d;
    ppy_q      <= ppy_d;
    preg_q     <= preg_d;
    pend_q     <= pend_d;
    res_q      <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ASSERT_IMP(a_mid_result_busy, clk_i, rst_ni, res_valid_o && !res_o.last, busy)
  `ASSERT_IMP(a_last_result_idle, clk_i, rst_ni, res_valid_o && res_o.last, !busy)
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_IMP(a_slot_write_phase, clk_i, rst_ni, sw_en, (state_q == S_SLOTDONE) || (state_q == S_CLEAR))

endmodule

// ===== test/grid_area_occupancy_index_test.sv =====
module grid_area_occupancy_index_test;

  // Register byte addresses on the APB port.
  localparam logic [gaoi_pkg::AddrW-1:0] RegWidth    = 4'd0;
  localparam logic [gaoi_pkg::AddrW-1:0] RegHeight   = 4'd4;
  localparam logic [gaoi_pkg::AddrW-1:0] RegCapacity = 4'd8;

  // Build limits of the instance under test.
  localparam int GridW  = 64;
  localparam int GridH  = 64;
  localparam int MaxObj = 256;
  localparam int MaxHalf = 2;
  localparam int MaxBox  = 64;
  localparam int MaxRes  = 64;

  // Function code 7 is not decoded by the block; it yields one empty result.
  localparam logic [2:0] FnUnused = 3'd7;

  // Settle time, longer than a table walk; wait this long after the last
  // result before touching the registers or ending the run.
  localparam int SettleCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  gaoi_pkg::cmd_t cmd_i = '0;
  logic res_valid_o;
  gaoi_pkg::res_t res_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gaoi_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  grid_area_occupancy_index DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // ---------------------------------------------------------------------------
  // Shadow of the index: occupancy counts, the object table and the registers.
  // ---------------------------------------------------------------------------
  logic [8:0]  occ_count [GridW*GridH];
  logic        obj_used  [MaxObj];
  logic [31:0] obj_ident [MaxObj];
  logic [5:0]  obj_col   [MaxObj];
  logic [5:0]  obj_row   [MaxObj];
  int unsigned obj_total;
  int unsigned cfg_width = 64, cfg_height = 64, cfg_cap = 256;

  // Results of the item being predicted.
  gaoi_pkg::res_t hits [$];
  bit   hit_overflow;

  gaoi_pkg::res_t expected_results [$];
  gaoi_pkg::cmd_t pending_cmds [$];
  int   pause_marks [$];      // item index at which the sender waits to drain

  int errors;
  int items_sent;
  int results_seen;
  int occupied_seen;
  int status_seen [8];

  function automatic int active_w();
    int w;
    w = cfg_width;
    if (w > GridW) w = GridW;
    return w;
  endfunction

  function automatic int active_h();
    int h;
    h = cfg_height;
    if (h > GridH) h = GridH;
    return h;
  endfunction

  function automatic bit on_grid(int px, int py);
    return px >= 0 && py >= 0 && px < active_w() && py < active_h();
  endfunction

  function automatic int lookup_ident(logic [31:0] ident);
    for (int i = 0; i < MaxObj; i++)
      if (obj_used[i] && obj_ident[i] == ident) return i;
    return -1;
  endfunction

  function automatic void push_hit(bit valid, int px, int py, int cnt, logic [1:0] rgn);
    gaoi_pkg::res_t r;
    if (hits.size() >= MaxRes) begin
      hit_overflow = 1'b1;
      return;
    end
    r = '0;
    r.cell_valid = valid;
    if (valid) begin
      r.cell_x = px[5:0];
      r.cell_y = py[5:0];
      r.cell_count = (cnt > 511) ? 9'd511 : cnt[8:0];
      r.region = rgn;
    end
    hits.push_back(r);
  endfunction

  function automatic void probe_cell(int px, int py, logic [1:0] rgn);
    int cnt;
    if (!on_grid(px, py)) return;
    cnt = occ_count[px*GridH + py];
    if (cnt != 0) push_hit(1'b1, px, py, cnt, rgn);
  endfunction

  // mode 0: plain window, 1: new window of a compare, 2: old window of a compare
  function automatic void sweep_window(int cx, int cy, int hw, int hh, int ox, int oy,
                                       int mode);
    int px, py;
    bit overlap;
    for (int i = 0; i <= 2*hw; i++)
      for (int j = 0; j <= 2*hh; j++) begin
        px = cx - hw + i;
        py = cy - hh + j;
        overlap = px >= ox - hw && px <= ox + hw && py >= oy - hh && py <= oy + hh;
        if (mode == 0) probe_cell(px, py, gaoi_pkg::RgnPlain);
        else if (mode == 1)
          probe_cell(px, py, overlap ? gaoi_pkg::RgnBoth : gaoi_pkg::RgnNew);
        else if (!overlap) probe_cell(px, py, gaoi_pkg::RgnOld);
      end
  endfunction

  // Applies one item to the shadow and queues the results it must produce.
  function automatic void predict_index(gaoi_pkg::cmd_t c);
    int x, y, x2, y2, hw, hh, slot, cap;
    longint boxcells;
    logic [2:0] st;
    x = c.x; y = c.y; x2 = c.x2; y2 = c.y2;
    hw = (c.half_w > MaxHalf) ? MaxHalf : c.half_w;
    hh = (c.half_h > MaxHalf) ? MaxHalf : c.half_h;
    st = gaoi_pkg::StOk;
    hits.delete();
    hit_overflow = 1'b0;
    case (c.func)
      gaoi_pkg::FnAdd: begin
        cap = (cfg_cap > MaxObj) ? MaxObj : cfg_cap;
        slot = -1;
        if (obj_total >= cap) st = gaoi_pkg::StFull;
        else if (lookup_ident(c.id) >= 0) st = gaoi_pkg::StExists;
        else if (!on_grid(x, y)) st = gaoi_pkg::StRange;
        else begin
          for (int i = 0; i < MaxObj; i++)
            if (!obj_used[i] && slot < 0) slot = i;
          if (slot < 0) st = gaoi_pkg::StFull;
          else begin
            obj_used[slot] = 1'b1;
            obj_ident[slot] = c.id;
            obj_col[slot] = x[5:0];
            obj_row[slot] = y[5:0];
            occ_count[x*GridH + y]++;
            obj_total++;
          end
        end
      end
      gaoi_pkg::FnDelete: begin
        slot = lookup_ident(c.id);
        if (slot < 0) st = gaoi_pkg::StNotFound;
        else begin
          if (occ_count[obj_col[slot]*GridH + obj_row[slot]] != 0)
            occ_count[obj_col[slot]*GridH + obj_row[slot]]--;
          obj_used[slot] = 1'b0;
          if (obj_total != 0) obj_total--;
        end
      end
      gaoi_pkg::FnMove: begin
        slot = lookup_ident(c.id);
        if (!on_grid(x, y)) st = gaoi_pkg::StRange;
        else if (slot < 0) st = gaoi_pkg::StNotFound;
        else begin
          if (occ_count[obj_col[slot]*GridH + obj_row[slot]] != 0)
            occ_count[obj_col[slot]*GridH + obj_row[slot]]--;
          obj_col[slot] = x[5:0];
          obj_row[slot] = y[5:0];
          occ_count[x*GridH + y]++;
        end
      end
      gaoi_pkg::FnCell: begin
        if (!on_grid(x, y)) st = gaoi_pkg::StRange;
        else probe_cell(x, y, gaoi_pkg::RgnPlain);
      end
      gaoi_pkg::FnWindow: sweep_window(x, y, hw, hh, 0, 0, 0);
      gaoi_pkg::FnCompare: begin
        sweep_window(x, y, hw, hh, x2, y2, 1);
        sweep_window(x2, y2, hw, hh, x, y, 2);
      end
      gaoi_pkg::FnBox: begin
        if (x2 >= x && y2 >= y) begin
          boxcells = longint'(x2 - x + 1) * longint'(y2 - y + 1);
          if (boxcells > MaxBox) st = gaoi_pkg::StTooLarge;
          else
            for (int px = x; px <= x2; px++)
              for (int py = y; py <= y2; py++)
                probe_cell(px, py, gaoi_pkg::RgnPlain);
        end
      end
      default: ;
    endcase
    if (hits.size() == 0) push_hit(1'b0, 0, 0, 0, gaoi_pkg::RgnPlain);
    if (hit_overflow) st = gaoi_pkg::StTooLarge;
    foreach (hits[k]) begin
      hits[k].status = st;
      hits[k].last = (k == hits.size() - 1);
      expected_results.push_back(hits[k]);
    end
  endfunction

  task automatic report_mismatch(string what, gaoi_pkg::res_t got, gaoi_pkg::res_t want);
    errors++;
    $display("[%0t] mismatch in %s: got st=%0d v=%0d (%0d,%0d) n=%0d rg=%0d l=%0d,",
             $realtime, what, got.status, got.cell_valid, got.cell_x, got.cell_y,
             got.cell_count, got.region, got.last,
             " want st=%0d v=%0d (%0d,%0d) n=%0d rg=%0d l=%0d", want.status,
             want.cell_valid, want.cell_x, want.cell_y, want.cell_count, want.region,
             want.last);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pulls items from pending_cmds, with a random gap between items.
  // start stays high until the accepting edge, then drops or moves on to the next
  // item in the same assignment chain that would otherwise re-raise it, so it is assigned once a step.
  // ---------------------------------------------------------------------------
  int gap_left;
  bit driver_en;
  bit hold_for_drain;

  always @(posedge clk_i) begin
    if (start && !busy) begin
      predict_index(cmd_i);
      items_sent++;
    end
    if (start && busy) begin
      // keep presenting the same item
    end else if (!driver_en || pending_cmds.size() == 0) begin
      start <= 1'b0;
    end else if (pause_marks.size() != 0 && pause_marks[0] == items_sent &&
                 expected_results.size() != 0) begin
      // sender holds off until every result of earlier items is out
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      if (pause_marks.size() != 0 && pause_marks[0] == items_sent)
        void'(pause_marks.pop_front());
      cmd_i <= pending_cmds.pop_front();
      start <= 1'b1;
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    end
  end

  // Monitor: every strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_o, '0);
      end else begin
        gaoi_pkg::res_t want;
        want = expected_results.pop_front();
        if (res_o.cell_valid) occupied_seen++;
        status_seen[res_o.status]++;
        if (res_o.status != want.status)         report_mismatch("status", res_o, want);
        else if (res_o.cell_valid != want.cell_valid) report_mismatch("cell_valid", res_o, want);
        else if (res_o.cell_x != want.cell_x)     report_mismatch("cell_x", res_o, want);
        else if (res_o.cell_y != want.cell_y)     report_mismatch("cell_y", res_o, want);
        else if (res_o.cell_count != want.cell_count) report_mismatch("cell_count", res_o, want);
        else if (res_o.region != want.region)     report_mismatch("region", res_o, want);
        else if (res_o.last != want.last)         report_mismatch("last", res_o, want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  logic [31:0] used_ids [$];

  function automatic gaoi_pkg::cmd_t make_cmd(logic [2:0] f, int x, int y, int x2, int y2,
                                              int hw, int hh, logic [31:0] ident);
    gaoi_pkg::cmd_t c;
    c.func = f;
    c.x = x[15:0]; c.y = y[15:0]; c.x2 = x2[15:0]; c.y2 = y2[15:0];
    c.half_w = hw[1:0]; c.half_h = hh[1:0];
    c.id = ident;
    return c;
  endfunction

  function automatic logic [31:0] pick_id();
    if (used_ids.size() != 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return $urandom();
  endfunction

  // Mostly small coordinates near the active grid, sometimes any 16-bit value.
  function automatic int pick_coord(int span);
    case ($urandom_range(0, 9))
      0: return $signed(16'($urandom()));
      1: return -$urandom_range(1, 3);
      default: return $urandom_range(0, span + 1);
    endcase
  endfunction

  function automatic gaoi_pkg::cmd_t random_cmd();
    gaoi_pkg::cmd_t c;
    int f, x, y, w, h;
    logic [31:0] ident;
    w = active_w(); h = active_h();
    if (w > 8) w = 8;   // keep objects clustered so queries find them
    if (h > 8) h = 8;
    f = $urandom_range(0, 99);
    x = pick_coord(w); y = pick_coord(h);
    ident = pick_id();
    if (f < 30) begin
      used_ids.push_back(ident);
      c = make_cmd(gaoi_pkg::FnAdd, x, y, 0, 0, 0, 0, ident);
    end else if (f < 38) c = make_cmd(gaoi_pkg::FnDelete, x, y, 0, 0, 0, 0, ident);
    else if (f < 48) c = make_cmd(gaoi_pkg::FnMove, x, y, 0, 0, 0, 0, ident);
    else if (f < 56) c = make_cmd(gaoi_pkg::FnCell, x, y, 0, 0, 0, 0, ident);
    else if (f < 70) c = make_cmd(gaoi_pkg::FnWindow, x, y, 0, 0, $urandom_range(0, 3),
                                  $urandom_range(0, 3), ident);
    else if (f < 82) c = make_cmd(gaoi_pkg::FnCompare, x, y, x + $urandom_range(0, 6) - 3,
                                  y + $urandom_range(0, 6) - 3, $urandom_range(0, 3),
                                  $urandom_range(0, 3), ident);
    else if (f < 96) c = make_cmd(gaoi_pkg::FnBox, x, y, x + $urandom_range(0, 9) - 1,
                                  y + $urandom_range(0, 9) - 1, 0, 0, ident);
    else c = make_cmd(FnUnused, x, y, 0, 0, 0, 0, ident);
    // scatter full-range values into the unused fields so every bit toggles
    if ($urandom_range(0, 4) == 0) begin
      if (c.func != gaoi_pkg::FnCompare && c.func != gaoi_pkg::FnBox) begin
        c.x2 = 16'($urandom()); c.y2 = 16'($urandom());
      end
      if (c.func != gaoi_pkg::FnWindow && c.func != gaoi_pkg::FnCompare) begin
        c.half_w = 2'($urandom()); c.half_h = 2'($urandom());
      end
    end
    return c;
  endfunction

  task automatic apb_write(logic [gaoi_pkg::AddrW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      RegWidth:  cfg_width  = data[6:0];
      RegHeight: cfg_height = data[6:0];
      default:   cfg_cap    = data[8:0];
    endcase
  endtask

  // Lets the driver run until all queued items are taken and answered.
  task automatic drain();
    driver_en = 1'b1;
    while (pending_cmds.size() != 0 || start || busy || expected_results.size() != 0)
      @(posedge clk_i);
    driver_en = 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int pause_at);
    for (int i = 0; i < n; i++) begin
      pending_cmds.push_back(random_cmd());
      // shadow registers are stable during a phase; sizes above only shape values
    end
    pause_marks.push_back(items_sent + pause_at);
    drain();
    pause_marks.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < GridW*GridH; i++) occ_count[i] = '0;
    for (int i = 0; i < MaxObj; i++) obj_used[i] = 1'b0;
    obj_total = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset
    do @(posedge clk_i); while (busy);

    // Directed: corners, every function, the error order and the special cases.
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 63, 63, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 63, 63, 0, 0, 0, 0,
                                    32'hFFFF_FFFF));                     // exists
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 64, 0, 0, 0, 0, 0, 32'h1)); // off grid
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, -1, 5, 0, 0, 0, 0, 32'h2)); // negative
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 1, 1, 0, 0, 0, 0, 32'hA5A5_5A5A));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnAdd, 1, 1, 0, 0, 0, 0, 32'h5A5A_A5A5));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnCell, 1, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnCell, 2, 2, 0, 0, 0, 0, 0));     // empty
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnCell, -32768, 32767, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnWindow, 1, 1, 0, 0, 3, 3, 0));   // saturated
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnWindow, 40, 40, 0, 0, 2, 2, 0)); // nothing
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnCompare, 1, 1, 3, 0, 1, 1, 0));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnCompare, 62, 62, 0, 0, 2, 2, 0));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnBox, 0, 0, 7, 7, 0, 0, 0));      // 64 cells
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnBox, 0, 0, 8, 7, 0, 0, 0));      // too large
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnBox, 5, 5, 4, 5, 0, 0, 0));      // reversed
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnBox, -32768, -32768, 32767, 32767,
                                    0, 0, 0));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnMove, 100, 0, 0, 0, 0, 0, 32'h7777));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnMove, 3, 3, 0, 0, 0, 0, 32'h7777));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnMove, 62, 63, 0, 0, 0, 0, 32'hA5A5_5A5A));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnDelete, 0, 0, 0, 0, 0, 0, 32'h5A5A_A5A5));
    pending_cmds.push_back(make_cmd(gaoi_pkg::FnDelete, 0, 0, 0, 0, 0, 0,
                                    32'h5A5A_A5A5));                     // gone
    pending_cmds.push_back(make_cmd(FnUnused, 1, 1, 1, 1, 1, 1, 32'h1));
    used_ids.push_back(32'h0); used_ids.push_back(32'hFFFF_FFFF);
    used_ids.push_back(32'hA5A5_5A5A);
    pause_marks.push_back(12);
    drain();
    pause_marks.delete();

    // Default registers, dense random traffic.
    random_phase(40, 20);

    // Tiny table and grid: full table and off-grid paths dominate.
    apb_write(RegCapacity, 32'd1);
    apb_write(RegWidth, 32'd1);
    apb_write(RegHeight, 32'd1);
    random_phase(20, 10);

    // Mid settings, with unused register bits set.
    apb_write(RegWidth, 32'hFFFF_FF85);   // 5 after masking
    apb_write(RegHeight, 32'd7);
    apb_write(RegCapacity, 32'hFFFF_FE0C); // 12
    random_phase(30, 15);

    // Zero grid and zero capacity.
    apb_write(RegWidth, 32'd0);
    apb_write(RegCapacity, 32'd0);
    random_phase(10, 5);

    // Width and capacity at their field maximum, height at the build limit, then a long random stretch.
    apb_write(RegWidth, 32'd127);
    apb_write(RegHeight, 32'd64);
    apb_write(RegCapacity, 32'd511);
    random_phase(50, 25);

    $display("items %0d, results %0d (%0d naming a cell)", items_sent, results_seen,
             occupied_seen);
    $display("status mix ok/full/exists/range/notfound/toolarge: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[gaoi_pkg::StOk], status_seen[gaoi_pkg::StFull],
             status_seen[gaoi_pkg::StExists], status_seen[gaoi_pkg::StRange],
             status_seen[gaoi_pkg::StNotFound], status_seen[gaoi_pkg::StTooLarge]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Timeout: covers the reset clearing pass, ~200 items with their gaps and
  // settle periods, with a wide margin.
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== grid_area_occupancy_index.f =====
+incdir+hdl
hdl/gaoi_pkg.sv
hdl/gaoi_regs.sv
hdl/grid_area_occupancy_index.sv
test/grid_area_occupancy_index_test.sv
